// ===== src/kjt_pkg.sv =====
`default_nettype none

package kjt_pkg;

	// Default sizing of the jump table.
	localparam int DEF_MAX_NODES = 1024;
	localparam int DEF_LEVELS    = 16;

	// Fixed port widths.
	localparam int OP_W       = 2;
	localparam int NODE_IDX_W = 10;
	localparam int PARENT_W   = 11;
	localparam int STEP_W     = 16;
	localparam int ANC_W      = 11;
	localparam int CNT_W      = 11;

	// Number of step bits a query walks through.
	localparam int STEP_BITS = 16;

	// Reset value of the node count register.
	localparam logic [CNT_W-1:0] NODE_COUNT_RST = 11'd1024;

	// Answer code for no ancestor.
	localparam logic [ANC_W-1:0] ANC_NONE = 11'h7FF;

	// Request operations.
	typedef enum logic [OP_W-1:0] {
		OP_LOAD  = 2'd0,
		OP_BUILD = 2'd1,
		OP_QUERY = 2'd2,
		OP_NOP   = 2'd3
	} op_t;

	// Sequencer states.
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_FIX_RD,
		ST_FIX_CHK,
		ST_LVL_RD,
		ST_LVL_MID,
		ST_LVL_WR,
		ST_Q_SCAN,
		ST_Q_WAIT,
		ST_Q_DONE
	} state_t;

endpackage

`default_nettype wire

// ===== src/kth_ancestor_jump_table_core.sv =====
`default_nettype none

// Binary-lifting k-th ancestor engine over a forest of up to MAX_NODES nodes.
// A load request writes one node's parent into level 0 of the jump table; the
// table is not cleared at reset, so every node in use must be loaded before a
// build. A build request first tidies level 0, node by node, and then fills
// each of the LEVELS-1 upper levels node by node from the level below. A query
// request walks the step bits from the lowest up to its highest set bit and
// reads the table once per set bit; queries are meaningful only after a build.
// All table traffic goes through one single-port memory with one shared address
// unit, and every read feeds the next address. The block takes one request at
// a time; a finished answer waits in the output register while the next request
// is accepted. node_count may be written only while idle.
module kth_ancestor_jump_table_core #(
	parameter int MAX_NODES = kjt_pkg::DEF_MAX_NODES,
	parameter int LEVELS    = kjt_pkg::DEF_LEVELS
) (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  cfg_valid,
	output logic                                 cfg_ready,
	input  wire         [kjt_pkg::CNT_W-1:0]      node_count,
	input  wire                                  in_valid,
	output logic                                 in_ready,
	input  wire         [kjt_pkg::OP_W-1:0]       op,
	input  wire         [kjt_pkg::NODE_IDX_W-1:0] node_index,
	input  wire  signed [kjt_pkg::PARENT_W-1:0]   parent_value,
	input  wire         [kjt_pkg::STEP_W-1:0]     step_count,
	output logic                                 out_valid,
	input  wire                                  out_ready,
	output logic signed [kjt_pkg::ANC_W-1:0]      ancestor
);

	localparam int NW    = $clog2(MAX_NODES);
	localparam int KW    = NW + 1;
	localparam int EW    = NW + 1;
	localparam int LW    = (LEVELS > 1) ? $clog2(LEVELS) : 1;
	localparam int DEPTH = MAX_NODES * LEVELS;
	localparam int AW    = $clog2(DEPTH);
	localparam int SBW   = $clog2(kjt_pkg::STEP_BITS + 1);

	localparam logic [EW-1:0] NONE_ENTRY = {1'b1, {NW{1'b0}}};

	kjt_pkg::state_t state_q, state_d;

	logic [kjt_pkg::CNT_W-1:0]  node_count_q;
	logic [KW-1:0]              j_q;
	logic [LW-1:0]              lvl_q;
	logic [NW-1:0]              cur_q;
	logic                       none_q;
	logic [kjt_pkg::STEP_W-1:0] steps_q;
	logic [SBW-1:0]             bit_q;
	logic                       out_valid_q;
	logic [kjt_pkg::ANC_W-1:0]  ancestor_q;

	logic              in_acc;
	kjt_pkg::op_t      in_op;
	logic [KW-1:0]     act_cnt;
	logic              j_last;
	logic              lvl_last;
	logic              rd_none;
	logic [NW-1:0]     rd_node;
	logic              mid_ok;
	logic              load_ok;
	logic [EW-1:0]     load_entry;
	logic              q_node_bad;
	logic              lvl_over;
	logic              q_finished;
	logic              out_free;

	logic              ram_we;
	logic [EW-1:0]     ram_wdata;
	logic [EW-1:0]     ram_rdata;
	logic [AW-1:0]     ram_addr;
	logic [NW-1:0]     node_sel;
	logic [LW-1:0]     lvl_sel;
	logic              node_adv;
	logic              q_shift;
	logic              q_take;
	logic              q_kill;
	logic              out_load;

	// Decode of the request, the node count and the table read data.
	assign in_acc     = in_valid && in_ready;
	assign in_op      = kjt_pkg::op_t'(op);
	assign act_cnt    = (32'(node_count_q) > MAX_NODES) ? KW'(MAX_NODES) : KW'(node_count_q);
	assign j_last     = (j_q + KW'(1)) == act_cnt;
	assign lvl_last   = lvl_q == LW'(LEVELS - 1);
	assign rd_none    = ram_rdata[EW-1];
	assign rd_node    = ram_rdata[NW-1:0];
	assign mid_ok     = !rd_none && (KW'(rd_node) < act_cnt);
	assign load_ok    = 32'(node_index) < MAX_NODES;
	assign load_entry = (parent_value[kjt_pkg::PARENT_W-1] ||
		(32'(parent_value[kjt_pkg::PARENT_W-2:0]) >= MAX_NODES)) ?
		NONE_ENTRY : {1'b0, NW'(parent_value[kjt_pkg::PARENT_W-2:0])};
	assign q_node_bad = 32'(node_index) >= 32'(act_cnt);
	assign lvl_over   = 32'(bit_q) >= LEVELS;
	assign q_finished = none_q || (steps_q == '0);
	assign out_free   = !out_valid_q || out_ready;

	// Shared address unit: node times level count plus level.
	assign ram_addr = AW'(node_sel) * AW'(LEVELS) + AW'(lvl_sel);

	kjt_ram #(
		.WIDTH (EW),
		.DEPTH (DEPTH)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	// Next-state logic of the sequencer.
	always_comb begin
		state_d = state_q;
		case (state_q)
			kjt_pkg::ST_IDLE: begin
				if (in_acc) begin
					case (in_op)
						kjt_pkg::OP_BUILD: begin
							state_d = (act_cnt == '0) ? kjt_pkg::ST_IDLE : kjt_pkg::ST_FIX_RD;
						end
						kjt_pkg::OP_QUERY: state_d = kjt_pkg::ST_Q_SCAN;
						default:           state_d = kjt_pkg::ST_IDLE;
					endcase
				end
			end
			kjt_pkg::ST_FIX_RD: state_d = kjt_pkg::ST_FIX_CHK;
			kjt_pkg::ST_FIX_CHK: begin
				if (j_last) begin
					state_d = (LEVELS > 1) ? kjt_pkg::ST_LVL_RD : kjt_pkg::ST_IDLE;
				end else begin
					state_d = kjt_pkg::ST_FIX_RD;
				end
			end
			kjt_pkg::ST_LVL_RD: state_d = kjt_pkg::ST_LVL_MID;
			kjt_pkg::ST_LVL_MID: begin
				if (mid_ok) begin
					state_d = kjt_pkg::ST_LVL_WR;
				end else if (j_last && lvl_last) begin
					state_d = kjt_pkg::ST_IDLE;
				end else begin
					state_d = kjt_pkg::ST_LVL_RD;
				end
			end
			kjt_pkg::ST_LVL_WR: begin
				state_d = (j_last && lvl_last) ? kjt_pkg::ST_IDLE : kjt_pkg::ST_LVL_RD;
			end
			kjt_pkg::ST_Q_SCAN: begin
				if (q_finished) begin
					state_d = kjt_pkg::ST_Q_DONE;
				end else if (steps_q[0] && !lvl_over) begin
					state_d = kjt_pkg::ST_Q_WAIT;
				end
			end
			kjt_pkg::ST_Q_WAIT: state_d = kjt_pkg::ST_Q_SCAN;
			kjt_pkg::ST_Q_DONE: begin
				if (out_free) begin
					state_d = kjt_pkg::ST_IDLE;
				end
			end
			default: state_d = kjt_pkg::ST_IDLE;
		endcase
	end

	// Output and control logic of the sequencer.
	always_comb begin
		in_ready  = 1'b0;
		ram_we    = 1'b0;
		ram_wdata = NONE_ENTRY;
		node_sel  = j_q[NW-1:0];
		lvl_sel   = '0;
		node_adv  = 1'b0;
		q_shift   = 1'b0;
		q_take    = 1'b0;
		q_kill    = 1'b0;
		out_load  = 1'b0;
		case (state_q)
			kjt_pkg::ST_IDLE: begin
				in_ready  = 1'b1;
				node_sel  = NW'(node_index);
				ram_wdata = load_entry;
				ram_we    = in_acc && (in_op == kjt_pkg::OP_LOAD) && load_ok;
			end
			kjt_pkg::ST_FIX_RD: begin
			end
			kjt_pkg::ST_FIX_CHK: begin
				// A parent that is a root or not in use becomes none.
				ram_we   = rd_none || (KW'(rd_node) >= act_cnt);
				node_adv = 1'b1;
			end
			kjt_pkg::ST_LVL_RD: begin
				lvl_sel = lvl_q - LW'(1);
			end
			kjt_pkg::ST_LVL_MID: begin
				if (mid_ok) begin
					node_sel = rd_node;
					lvl_sel  = lvl_q - LW'(1);
				end else begin
					lvl_sel  = lvl_q;
					ram_we   = 1'b1;
					node_adv = 1'b1;
				end
			end
			kjt_pkg::ST_LVL_WR: begin
				lvl_sel   = lvl_q;
				ram_wdata = ram_rdata;
				ram_we    = 1'b1;
				node_adv  = 1'b1;
			end
			kjt_pkg::ST_Q_SCAN: begin
				node_sel = cur_q;
				lvl_sel  = bit_q[LW-1:0];
				if (!q_finished) begin
					if (!steps_q[0]) begin
						q_shift = 1'b1;
					end else if (lvl_over) begin
						q_kill = 1'b1;
					end
				end
			end
			kjt_pkg::ST_Q_WAIT: begin
				q_shift = 1'b1;
				if (rd_none) begin
					q_kill = 1'b1;
				end else begin
					q_take = 1'b1;
				end
			end
			kjt_pkg::ST_Q_DONE: begin
				out_load = out_free;
			end
			default: begin
			end
		endcase
	end

	// Sequencer state and configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= kjt_pkg::ST_IDLE;
			node_count_q <= kjt_pkg::NODE_COUNT_RST;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				node_count_q <= node_count;
			end
		end
	end

	assign cfg_ready = 1'b1;

	// Build node and level counters.
	always_ff @(posedge clk) begin
		if (in_acc && (in_op == kjt_pkg::OP_BUILD)) begin
			j_q   <= '0;
			lvl_q <= '0;
		end else if (node_adv) begin
			if (j_last) begin
				j_q   <= '0;
				lvl_q <= lvl_q + LW'(1);
			end else begin
				j_q <= j_q + KW'(1);
			end
		end
	end

	// Query walk registers.
	always_ff @(posedge clk) begin
		if (in_acc && (in_op == kjt_pkg::OP_QUERY)) begin
			cur_q   <= NW'(node_index);
			none_q  <= q_node_bad;
			steps_q <= step_count;
			bit_q   <= '0;
		end else begin
			if (q_take) begin
				cur_q <= rd_node;
			end
			if (q_kill) begin
				none_q <= 1'b1;
			end
			if (q_shift) begin
				steps_q <= steps_q >> 1;
				bit_q   <= bit_q + SBW'(1);
			end
		end
	end

	// Output register holding the answer until it is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			ancestor_q <= none_q ? kjt_pkg::ANC_NONE : kjt_pkg::ANC_W'(cur_q);
		end
	end

	assign out_valid = out_valid_q;
	assign ancestor  = ancestor_q;

`ifndef SYNTH
	// The table is never written while a query walks it.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == kjt_pkg::ST_Q_SCAN || state_q == kjt_pkg::ST_Q_WAIT ||
		 state_q == kjt_pkg::ST_Q_DONE) |-> !ram_we)
	else $error("table written during a query");

	// The build counter stays inside the nodes in use.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == kjt_pkg::ST_FIX_RD || state_q == kjt_pkg::ST_FIX_CHK ||
		 state_q == kjt_pkg::ST_LVL_RD || state_q == kjt_pkg::ST_LVL_MID ||
		 state_q == kjt_pkg::ST_LVL_WR) |-> (j_q < act_cnt))
	else $error("build counter beyond node count");

	// A finished query with a free output register shows its answer next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == kjt_pkg::ST_Q_DONE && out_free) |=>
		(out_valid && state_q == kjt_pkg::ST_IDLE))
	else $error("query answer not delivered");

	// The query bit index never runs past the step width.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == kjt_pkg::ST_Q_SCAN) |-> (32'(bit_q) <= kjt_pkg::STEP_BITS))
	else $error("query bit index overrun");
`endif

endmodule

`default_nettype wire

// ===== src/kjt_ram.sv =====
`default_nettype none

module kjt_ram #(
	parameter int WIDTH = 11,
	parameter int DEPTH = 16384
) (
	input  wire                      clk,
	input  wire                      we,
	input  wire  [$clog2(DEPTH)-1:0] addr,
	input  wire  [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Single port with a registered read.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata_q <= mem[addr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire
